>>> src/jsof_pkg.sv
// Package for the JPEG start-of-frame dimension scanner.
// Holds the marker codes, the parser phase type and the state and result structs.
// No dependencies; used by jsof_parse and jpeg_sof_dimension_scanner.
package jsof_pkg;

  localparam logic [7:0] MARK_PREFIX = 8'hFF;
  localparam logic [7:0] MARK_SOI    = 8'hD8;
  localparam logic [7:0] MARK_RST0   = 8'hD0;
  localparam logic [7:0] MARK_EOI    = 8'hD9;
  localparam logic [7:0] MARK_SOF_LO = 8'hC0;
  localparam logic [7:0] MARK_SOF_HI = 8'hCF;
  localparam logic [7:0] MARK_DHT    = 8'hC4;
  localparam logic [7:0] MARK_JPG    = 8'hC8;
  localparam logic [7:0] MARK_DAC    = 8'hCC;

  localparam logic [15:0] LEN_MIN       = 16'd2;
  localparam logic [15:0] FRAME_MIN_LEN = 16'd7;
  localparam logic [15:0] OFS_HEIGHT_HI = 16'd3;
  localparam logic [15:0] OFS_HEIGHT_LO = 16'd4;
  localparam logic [15:0] OFS_WIDTH_HI  = 16'd5;
  localparam logic [15:0] OFS_WIDTH_LO  = 16'd6;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  typedef enum logic [6:0] {
    PH_SIG0   = 7'b0000001,
    PH_SIG1   = 7'b0000010,
    PH_SEARCH = 7'b0000100,
    PH_MARK   = 7'b0001000,
    PH_LENHI  = 7'b0010000,
    PH_LENLO  = 7'b0100000,
    PH_BODY   = 7'b1000000
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [15:0] seg_length;
    logic [15:0] seg_offset;
    logic        frame_seg;
    logic [15:0] height;
    logic [15:0] width;
    logic        verdict_given;
  } scan_state_t;

  typedef struct packed {
    logic        valid;
    logic        status;
    logic [15:0] width;
    logic [15:0] height;
  } scan_result_t;

  localparam scan_state_t STATE_CLEAR = '{
    phase:         PH_SIG0,
    seg_length:    16'd0,
    seg_offset:    16'd0,
    frame_seg:     1'b0,
    height:        16'd0,
    width:         16'd0,
    verdict_given: 1'b0
  };

endpackage

>>> src/jsof_parse.sv
// Next-state and verdict logic for one byte of the JPEG marker walk.
// Purely combinational; uses the types and marker codes of jsof_pkg.
module jsof_parse import jsof_pkg::*; (
  input  scan_state_t  st,
  input  logic [7:0]   data_byte,
  input  logic         last_byte,
  output scan_state_t  st_next,
  output scan_result_t res
);

  logic        fail;
  logic        done;
  logic [15:0] ofs_inc;
  logic [15:0] len_full;
  logic [15:0] target;
  logic        is_sof;
  logic        is_standalone;
  scan_state_t work;

  always_comb begin
    ofs_inc       = st.seg_offset + 16'd1;
    len_full      = {st.seg_length[15:8], data_byte};
    target        = (st.seg_length < FRAME_MIN_LEN) ? FRAME_MIN_LEN : st.seg_length;
    is_sof        = (data_byte >= MARK_SOF_LO) && (data_byte <= MARK_SOF_HI) &&
                    (data_byte != MARK_DHT) && (data_byte != MARK_JPG) &&
                    (data_byte != MARK_DAC);
    is_standalone = (data_byte >= MARK_RST0) && (data_byte <= MARK_EOI);
    work          = st;
    fail          = 1'b0;
    done          = 1'b0;

    if (!st.verdict_given) begin
      case (st.phase)
        PH_SIG0: begin
          if (data_byte == MARK_PREFIX) work.phase = PH_SIG1;
          else fail = 1'b1;
        end
        PH_SIG1: begin
          if (data_byte == MARK_SOI) work.phase = PH_SEARCH;
          else fail = 1'b1;
        end
        PH_SEARCH: begin
          if (data_byte == MARK_PREFIX) work.phase = PH_MARK;
        end
        PH_MARK: begin
          if (data_byte != MARK_PREFIX) begin
            if (is_standalone) begin
              work.phase = PH_SEARCH;
            end else begin
              work.frame_seg = is_sof;
              work.phase     = PH_LENHI;
            end
          end
        end
        PH_LENHI: begin
          work.seg_length = {data_byte, 8'd0};
          work.phase      = PH_LENLO;
        end
        PH_LENLO: begin
          work.seg_length = len_full;
          work.seg_offset = LEN_MIN;
          work.height     = 16'd0;
          work.width      = 16'd0;
          if (len_full < LEN_MIN) fail = 1'b1;
          else if (!st.frame_seg && (len_full == LEN_MIN)) work.phase = PH_SEARCH;
          else work.phase = PH_BODY;
        end
        PH_BODY: begin
          work.seg_offset = ofs_inc;
          if (st.frame_seg) begin
            if (st.seg_offset == OFS_HEIGHT_HI) work.height[15:8] = data_byte;
            if (st.seg_offset == OFS_HEIGHT_LO) work.height[7:0]  = data_byte;
            if (st.seg_offset == OFS_WIDTH_HI)  work.width[15:8]  = data_byte;
            if (st.seg_offset == OFS_WIDTH_LO)  work.width[7:0]   = data_byte;
            if (ofs_inc == target) done = 1'b1;
          end else if (ofs_inc >= st.seg_length) begin
            work.phase = PH_SEARCH;
          end
        end
        default: begin
          fail = 1'b1;
        end
      endcase
      if (!done && last_byte) fail = 1'b1;
    end

    res.valid  = fail || done;
    res.status = fail ? STATUS_FAIL : STATUS_OK;
    res.width  = fail ? 16'd0 : work.width;
    res.height = fail ? 16'd0 : work.height;

    if (res.valid) work.verdict_given = 1'b1;
    st_next = last_byte ? STATE_CLEAR : work;
  end

endmodule

>>> src/jpeg_sof_dimension_scanner.sv
// Top level of the JPEG start-of-frame dimension scanner.
// Input word register, scanner state, result register; uses jsof_pkg and jsof_parse.
//
// Channel | Dir | tdata                          | tuser        | tlast
// s_axis  | in  | [7:0] data_byte                | -            | last_byte
// m_axis  | out | [15:0] image_width,            | scan_status  | -
//         |     | [31:16] image_height           |              |
//
// Each input word is held in the input register and is then parsed into the result
// register, from which any verdict that it causes is offered on m_axis.
// The block takes one word per cycle as long as the result register is empty or is
// read out in the same cycle.
// A stalled result holds the parse stage, which then holds the input register.
// Synchronous active-high reset clears the state to await the signature.
module jpeg_sof_dimension_scanner import jsof_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [15:0] image_width, [31:16] image_height
  output logic        m_axis_tuser    // [0] scan_status
);

  logic         in_valid;
  logic [7:0]   in_data;
  logic         in_last;
  logic         advance;
  scan_state_t  st;
  scan_state_t  st_next;
  scan_result_t res;

  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  jsof_parse u_parse (
    .st        (st),
    .data_byte (in_data),
    .last_byte (in_last),
    .st_next   (st_next),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
    if (s_axis_tready && s_axis_tvalid) begin
      in_data <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= STATE_CLEAR;
    end else if (advance) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= res.valid;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
    if (advance && res.valid) begin
      m_axis_tdata <= {res.height, res.width};
      m_axis_tuser <= res.status;
    end
  end

  a_one_verdict: assert property (@(posedge clk) disable iff (rst)
    advance && st.verdict_given |-> !res.valid)
    else $error("Second verdict for one stream.");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == STATUS_FAIL) |-> (m_axis_tdata == 32'd0))
    else $error("Failure verdict carries nonzero dimensions.");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    advance && in_last |=> (st.phase == PH_SIG0) && !st.verdict_given)
    else $error("Last word did not return the scanner to its start state.");

  a_ready_held: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> in_valid && m_axis_tvalid && !m_axis_tready)
    else $error("Input stalled without a stalled result.");

endmodule

>>> bench/tb_jpeg_sof_dimension_scanner.sv
// Self-checking bench for jpeg_sof_dimension_scanner: JPEG-like files go in a word at a time
// and every start-of-frame verdict is checked against a scan model kept in the bench.
// Depends on jsof_pkg and the scanner RTL; needs no files or arguments.
module tb_jpeg_sof_dimension_scanner;
  import jsof_pkg::*;

  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 10;

  typedef enum {GAPS_OFF, GAPS_SENDER, GAPS_RECEIVER, GAPS_BOTH} gap_mode_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } file_word_t;

  typedef struct packed {
    logic        status;
    logic [15:0] width;
    logic [15:0] height;
  } dim_verdict_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;

  gap_mode_t    gap_mode = GAPS_OFF;
  file_word_t   pending_words[$];
  logic [7:0]   file_bytes[$];
  dim_verdict_t verdicts_due[$];
  bit           word_taken = 1'b0;
  int           words_queued = 0;
  int           words_accepted = 0;
  int           files_sent = 0;
  int           frames_found = 0;
  int           scans_failed = 0;
  int           mismatches = 0;
  int           stalled_cycles = 0;

  phase_t      scan_ph;
  logic [2:0]  lead_cnt;
  logic [15:0] seg_len;
  logic [15:0] seg_pos;
  logic [15:0] hgt_acc;
  logic [15:0] wid_acc;
  logic        in_frame;
  logic        decided;

  jpeg_sof_dimension_scanner dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit is_frame_marker(input logic [7:0] b);
    return b >= MARK_SOF_LO && b <= MARK_SOF_HI && b != MARK_DHT && b != MARK_JPG &&
           b != MARK_DAC;
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom);
  endfunction

  function automatic bit roll(input int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic int gap_pct(input bit receiver_side);
    if (gap_mode == GAPS_BOTH) return 27;
    if (gap_mode == (receiver_side ? GAPS_RECEIVER : GAPS_SENDER)) return 73;
    return 0;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic clear_scan();
    scan_ph  = PH_SIG0;
    lead_cnt = 3'd0;
    seg_len  = 16'd0;
    seg_pos  = 16'd0;
    hgt_acc  = 16'd0;
    wid_acc  = 16'd0;
    in_frame = 1'b0;
    decided  = 1'b0;
  endtask

  // Advances the scan model by one word and queues the verdict it causes, if any.
  task automatic scan_word(input logic [7:0] b, input logic lst);
    logic        emit;
    logic        status;
    logic [15:0] target;
    emit   = 1'b0;
    status = STATUS_FAIL;
    if (!decided) begin
      if (lead_cnt < 3'd4) lead_cnt++;
      case (scan_ph)
        PH_SIG0: if (b == MARK_PREFIX) scan_ph = PH_SIG1; else emit = 1'b1;
        PH_SIG1: if (b == MARK_SOI) scan_ph = PH_SEARCH; else emit = 1'b1;
        PH_SEARCH: if (b == MARK_PREFIX) scan_ph = PH_MARK;
        PH_MARK: begin
          if (b != MARK_PREFIX) begin
            if (b >= MARK_RST0 && b <= MARK_EOI) begin
              scan_ph = PH_SEARCH;
            end else begin
              in_frame = is_frame_marker(b);
              scan_ph  = PH_LENHI;
            end
          end
        end
        PH_LENHI: begin
          seg_len = {b, 8'h00};
          scan_ph = PH_LENLO;
        end
        PH_LENLO: begin
          seg_len = {seg_len[15:8], b};
          seg_pos = 16'd2;
          hgt_acc = 16'd0;
          wid_acc = 16'd0;
          if (seg_len < LEN_MIN) emit = 1'b1;
          else if (!in_frame && seg_len == LEN_MIN) scan_ph = PH_SEARCH;
          else scan_ph = PH_BODY;
        end
        PH_BODY: begin
          if (in_frame) begin
            target = (seg_len < FRAME_MIN_LEN) ? FRAME_MIN_LEN : seg_len;
            case (seg_pos)
              OFS_HEIGHT_HI: hgt_acc[15:8] = b;
              OFS_HEIGHT_LO: hgt_acc[7:0] = b;
              OFS_WIDTH_HI:  wid_acc[15:8] = b;
              OFS_WIDTH_LO:  wid_acc[7:0] = b;
              default: ;
            endcase
            seg_pos = seg_pos + 16'd1;
            if (seg_pos == target && lead_cnt >= 3'd4) begin
              status = STATUS_OK;
              emit   = 1'b1;
            end
          end else begin
            seg_pos = seg_pos + 16'd1;
            if (seg_pos >= seg_len) scan_ph = PH_SEARCH;
          end
        end
        default: ;
      endcase
      if (lst) emit = 1'b1;
    end
    if (emit) begin
      decided = 1'b1;
      if (status == STATUS_OK) frames_found++; else scans_failed++;
      verdicts_due.push_back('{status: status,
                               width: (status == STATUS_OK) ? wid_acc : 16'd0,
                               height: (status == STATUS_OK) ? hgt_acc : 16'd0});
    end
    if (lst) clear_scan();
  endtask

  task automatic send_file();
    foreach (file_bytes[i]) pending_words.push_back('{file_bytes[i], i == file_bytes.size() - 1});
    words_queued += file_bytes.size();
    files_sent++;
  endtask

  task automatic add_segment(input logic [15:0] len);
    file_bytes.push_back(len[15:8]);
    file_bytes.push_back(len[7:0]);
    if (len >= 16'd2) repeat (len - 16'd2) file_bytes.push_back(rand_byte());
  endtask

  // Builds one file: mostly well-formed with random segments, sometimes broken or cut short.
  task automatic gen_file();
    int          kind;
    int          body_len;
    int          cut;
    logic [7:0]  mk;
    logic [15:0] len;
    logic [31:0] dims;
    file_bytes.delete();
    kind = $urandom_range(0, 99);
    if (kind < 6) begin
      repeat ($urandom_range(1, 6)) file_bytes.push_back(rand_byte());
    end else if (kind < 9) begin
      file_bytes.push_back(8'($urandom_range(0, 254)));
      repeat ($urandom_range(0, 4)) file_bytes.push_back(rand_byte());
    end else if (kind < 13) begin
      file_bytes.push_back(MARK_PREFIX);
      do mk = rand_byte(); while (mk == MARK_SOI);
      file_bytes.push_back(mk);
      repeat ($urandom_range(0, 4)) file_bytes.push_back(rand_byte());
    end else begin
      file_bytes.push_back(MARK_PREFIX);
      file_bytes.push_back(MARK_SOI);
      repeat ($urandom_range(0, 3)) begin
        repeat ($urandom_range(0, 1)) file_bytes.push_back(8'($urandom_range(0, 254)));
        file_bytes.push_back(MARK_PREFIX);
        repeat ($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0)
          file_bytes.push_back(MARK_PREFIX);
        if ($urandom_range(0, 3) == 0) begin
          file_bytes.push_back(8'($urandom_range(MARK_RST0, MARK_EOI)));
        end else begin
          do mk = rand_byte();
          while (mk == MARK_PREFIX || (mk >= MARK_RST0 && mk <= MARK_EOI) || is_frame_marker(mk));
          file_bytes.push_back(mk);
          if ($urandom_range(0, 99) < 4) len = 16'($urandom_range(0, 1));
          else if ($urandom_range(0, 99) < 2) len = 16'($urandom_range(256, 300));
          else len = 16'($urandom_range(2, 8));
          add_segment(len);
        end
      end
      file_bytes.push_back(MARK_PREFIX);
      repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0)
        file_bytes.push_back(MARK_PREFIX);
      do mk = 8'($urandom_range(MARK_SOF_LO, MARK_SOF_HI)); while (!is_frame_marker(mk));
      file_bytes.push_back(mk);
      kind = $urandom_range(0, 99);
      if (kind < 12) len = 16'($urandom_range(0, 6));
      else if (kind < 22) len = 16'($urandom_range(13, 40));
      else len = 16'($urandom_range(7, 12));
      file_bytes.push_back(len[15:8]);
      file_bytes.push_back(len[7:0]);
      kind = $urandom_range(0, 9);
      dims = (kind == 0) ? 32'h0 : (kind == 1) ? 32'hFFFF_FFFF : $urandom;
      body_len = ((len < FRAME_MIN_LEN) ? FRAME_MIN_LEN : len) - 2;
      for (int i = 0; i < body_len; i++) begin
        if (i >= 1 && i <= 4) file_bytes.push_back(dims[8 * (4 - i) +: 8]);
        else file_bytes.push_back(rand_byte());
      end
      repeat ($urandom_range(0, 3)) file_bytes.push_back(rand_byte());
      if ($urandom_range(0, 99) < 12) begin
        cut = $urandom_range(1, file_bytes.size());
        while (file_bytes.size() > cut) void'(file_bytes.pop_back());
      end
    end
    send_file();
  endtask

  task automatic wait_drained();
    while (words_accepted != words_queued) @(negedge clk);
  endtask

  always @(negedge clk) begin : feed_words
    file_word_t w;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      m_axis_tready <= 1'b0;
    end else begin
      if (!s_axis_tvalid || word_taken) begin
        word_taken = 1'b0;
        if (pending_words.size() != 0 && !roll(gap_pct(1'b0))) begin
          w = pending_words.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= w.data;
          s_axis_tlast  <= w.last;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= !roll(gap_pct(1'b1));
    end
  end

  always @(posedge clk) begin : watch_ports
    dim_verdict_t due;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (verdicts_due.size() == 0) begin
          report_mismatch($sformatf("verdict with none due: status %0b width %0d height %0d",
                                    m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[31:16]));
        end else begin
          due = verdicts_due.pop_front();
          if (m_axis_tuser !== due.status)
            report_mismatch($sformatf("scan_status %0b, expected %0b", m_axis_tuser, due.status));
          if (m_axis_tdata[15:0] !== due.width)
            report_mismatch($sformatf("image_width %0d, expected %0d",
                                      m_axis_tdata[15:0], due.width));
          if (m_axis_tdata[31:16] !== due.height)
            report_mismatch($sformatf("image_height %0d, expected %0d",
                                      m_axis_tdata[31:16], due.height));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        scan_word(s_axis_tdata, s_axis_tlast);
        words_accepted++;
        word_taken = 1'b1;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stalled_cycles = 0;
    else
      stalled_cycles++;
    if (stalled_cycles >= STALL_LIMIT) begin
      $display("no word moved for %0d cycles", STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin : run_scans
    int start_words;
    int start_files;
    clear_scan();
    repeat (2) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Truncated one-word file, bad first byte with ignored tail, bad second byte.
    file_bytes = '{MARK_PREFIX};
    send_file();
    file_bytes = '{8'h00, MARK_SOI};
    send_file();
    file_bytes = '{MARK_PREFIX, 8'h12};
    send_file();
    // Fill bytes and a restart marker, then a frame header whose length is below the minimum.
    file_bytes = '{MARK_PREFIX, MARK_SOI, MARK_PREFIX, MARK_PREFIX, MARK_RST0, MARK_PREFIX,
                   MARK_SOF_LO, 8'h00, 8'h00};
    send_file();
    // Short frame header that still waits for seven words, largest dimensions.
    file_bytes = '{MARK_PREFIX, MARK_SOI, MARK_PREFIX, MARK_SOF_HI, 8'h00, 8'h05, 8'h08,
                   8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_file();
    wait_drained();

    for (int m = 0; m < 4; m++) begin
      gap_mode    = gap_mode_t'(m);
      start_words = words_queued;
      start_files = files_sent;
      while (words_queued - start_words < 175 || files_sent - start_files < 5) gen_file();
      wait_drained();
    end

    while (verdicts_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Streamed %0d files (%0d words) under four idle patterns.", files_sent,
             words_accepted);
    $display("Verdicts checked: %0d frame headers found, %0d scans failed, %0d mismatches.",
             frames_found, scans_failed, mismatches);
    if (mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
